@@ rtl/core/m31_pkg.sv @@
// Package: opcodes, field constants and reduction helpers for the Mersenne-31 ALU.
package m31_pkg;

    localparam int unsigned W = 31;
    localparam logic [W-1:0] P = 31'h7FFF_FFFF;
    localparam int unsigned EXP_BITS = 31;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_NEG  = 5'd2,  OP_MUL  = 5'd3,
        OP_DIV  = 5'd4,  OP_INV  = 5'd5,  OP_POW  = 5'd6,  OP_IDIV = 5'd7,
        OP_MOD  = 5'd8,  OP_BAND = 5'd9,  OP_BOR  = 5'd10, OP_BXOR = 5'd11,
        OP_BNOT = 5'd12, OP_SHL  = 5'd13, OP_SHR  = 5'd14, OP_EQ   = 5'd15,
        OP_NEQ  = 5'd16, OP_LT   = 5'd17, OP_GT   = 5'd18, OP_LEQ  = 5'd19,
        OP_GEQ  = 5'd20, OP_LAND = 5'd21, OP_LOR  = 5'd22, OP_LNOT = 5'd23
    } t_op;

    typedef struct packed {
        logic          start;
        logic [W-1:0]  x;
        logic [W-1:0]  y;
    } t_mul_req;

    // fold a 32-bit value (< 2P+1) to 0..P-1
    function automatic logic [W-1:0] fold32(input logic [W:0] v);
        logic [W+1:0] s;
        s = {1'b0, v[W-1:0]} + {{W{1'b0}}, v[W]};
        if (s[W-1:0] == P || s[W]) begin
            fold32 = s[W-1:0] + {{(W-1){1'b0}}, s[W]} - (s[W-1:0] == P ? P : '0);
        end else begin
            fold32 = s[W-1:0];
        end
    endfunction

    function automatic logic [W-1:0] red31(input logic [W-1:0] v);
        red31 = (v == P) ? '0 : v;
    endfunction

endpackage

@@ rtl/core/m31_mul.sv @@
// Modular multiplier mod 2^31-1: registered product then Mersenne fold.
module m31_mul
    import m31_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mul_req      i_req,
    output logic          o_done,
    output logic [W-1:0]  o_prod
);
    logic [2*W-1:0] r_prod;
    logic           r_stage;
    logic           r_done;
    logic [W-1:0]   r_res;
    logic [W:0]     n_sum;

    assign n_sum = {1'b0, r_prod[W-1:0]} + {1'b0, r_prod[2*W-1:W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_req.start;
            r_done  <= r_stage;
        end
        if (i_req.start) begin
            r_prod <= i_req.x * i_req.y;
        end
        if (r_stage) begin
            r_res <= fold32(n_sum);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_res;

    a_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> ##1 o_done) else $error("mul done missing");
    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_prod != P) else $error("mul result not reduced");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_req.start, 2)) else $error("spurious mul done");
endmodule

@@ rtl/core/m31_div.sv @@
// Restoring integer divider, one quotient bit per cycle.
module m31_div
    import m31_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    output logic          o_done,
    output logic [W-1:0]  o_quo,
    output logic [W-1:0]  o_rem
);
    logic [W-1:0] r_quo, r_rem, r_den;
    logic [4:0]   r_cnt;
    logic         r_busy, r_done;
    logic [W:0]   n_shift;
    logic [W:0]   n_diff;

    assign n_shift = {r_rem, r_quo[W-1]};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!n_diff[W]) begin
                r_rem <= n_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_den != '0) |-> o_rem < r_den) else $error("remainder too big");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("div done held");
    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_done) else $error("done while busy");
endmodule

@@ rtl/core/mersenne31_field_alu.sv @@
// Top level: Mersenne-31 field ALU with sequencer over shared multiplier and divider.
// Simple ops and shl are computed in S_EXEC; mul waits in S_MWAIT; idiv/mod wait in S_DWAIT.
// pow/inv/div run square-and-multiply rounds on the shared 2-stage multiplier,
// each multiply taking issue, two stages and a step; div adds a final multiply by a.
// One word in flight; o_s_tready is low from accept until the result word is taken.
// Synchronous active-low reset clears the sequencer and output valid.
module mersenne31_field_alu
    import m31_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [71:0]   i_s_tdata,   // operation[4:0], operand_a[35:5], operand_b[66:36]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [31:0]   o_m_tdata    // result_value[30:0], error_flag[31]
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_EXEC = 6'b000010, S_MWAIT = 6'b000100,
        S_DWAIT = 6'b001000, S_FIN = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state       r_state;
    t_op          r_op;
    logic [W-1:0] r_a, r_b, r_base, r_exp, r_acc, r_res;
    logic [4:0]   r_bit;
    logic         r_phase;   // 0 square, 1 multiply by base
    logic         r_final;   // div: last multiply by a pending
    logic         r_err;
    t_mul_req     n_req;
    logic         w_mdone, w_ddone, n_dstart;
    logic [W-1:0] w_prod, w_quo, w_rem, w_a, w_b;
    logic [W:0]   w_sum, w_sub;
    logic [W-1:0] n_simple;
    logic [7:0]   w_dsum;
    logic [5:0]   w_dsum2;
    logic [4:0]   w_dsum3;
    logic [4:0]   w_shamt;
    logic [2*W-1:0] w_rot;

    assign w_a = red31(i_s_tdata[35:5]);
    assign w_b = red31(i_s_tdata[66:36]);
    assign w_sum = {1'b0, r_a} + {1'b0, r_b};
    assign w_sub = {1'b0, r_a} + {1'b0, P} - {1'b0, r_b};

    // a * 2^b mod P is a 31-bit rotate by b mod 31; 32 = 1 mod 31, so sum 5-bit digits
    assign w_dsum  = 8'(r_b[4:0]) + 8'(r_b[9:5]) + 8'(r_b[14:10]) + 8'(r_b[19:15])
                   + 8'(r_b[24:20]) + 8'(r_b[29:25]) + 8'(r_b[30]);
    assign w_dsum2 = 6'(w_dsum[4:0]) + 6'(w_dsum[7:5]);
    assign w_dsum3 = w_dsum2[4:0] + 5'(w_dsum2[5]);
    assign w_shamt = (w_dsum3 == 5'd31) ? 5'd0 : w_dsum3;
    assign w_rot   = {r_a, r_a} << w_shamt;

    always_comb begin
        n_simple = '0;
        case (r_op)
            OP_ADD:  n_simple = fold32(w_sum);
            OP_SUB:  n_simple = fold32(w_sub);
            OP_NEG:  n_simple = (r_a == '0) ? '0 : P - r_a;
            OP_BAND: n_simple = red31(r_a & r_b);
            OP_BOR:  n_simple = red31(r_a | r_b);
            OP_BXOR: n_simple = red31(r_a ^ r_b);
            // 2^64-1 = 3 mod P, so result is (3 - a) mod P
            OP_BNOT: n_simple = fold32({1'b0, P} + 32'd3 - {1'b0, r_a});
            OP_SHL:  n_simple = w_rot[2*W-1:W];
            OP_SHR:  n_simple = (r_b >= 31'd31) ? '0 : (r_a >> r_b[4:0]);
            OP_EQ:   n_simple = W'(r_a == r_b);
            OP_NEQ:  n_simple = W'(r_a != r_b);
            OP_LT:   n_simple = W'(r_a < r_b);
            OP_GT:   n_simple = W'(r_a > r_b);
            OP_LEQ:  n_simple = W'(r_a <= r_b);
            OP_GEQ:  n_simple = W'(r_a >= r_b);
            OP_LAND: n_simple = W'(r_a != '0 && r_b != '0);
            OP_LOR:  n_simple = W'(r_a != '0 || r_b != '0);
            OP_LNOT: n_simple = W'(r_a == '0);
            default: n_simple = '0;
        endcase
    end

    m31_mul u_mul (.i_clk, .i_rst_n, .i_req(n_req), .o_done(w_mdone), .o_prod(w_prod));
    m31_div u_div (.i_clk, .i_rst_n, .i_start(n_dstart), .i_num(r_a), .i_den(r_b),
                   .o_done(w_ddone), .o_quo(w_quo), .o_rem(w_rem));

    always_comb begin
        n_req = '{start: 1'b0, x: r_acc, y: r_acc};
        n_dstart = 1'b0;
        if (r_state == S_EXEC) begin
            case (r_op)
                OP_MUL: n_req = '{start: 1'b1, x: r_a, y: r_b};
                OP_DIV, OP_INV, OP_POW:
                    n_req = '{start: 1'b1, x: r_acc, y: r_phase ? r_base : r_acc};
                OP_IDIV, OP_MOD: n_dstart = (r_b != '0);
                default: n_req.start = 1'b0;
            endcase
            if (r_final) n_req = '{start: 1'b1, x: r_acc, y: r_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= t_op'(i_s_tdata[4:0]);
                        r_a     <= w_a;
                        r_b     <= w_b;
                        r_acc   <= W'(1);
                        r_bit   <= 5'(EXP_BITS - 1);
                        r_phase <= 1'b0;
                        r_final <= 1'b0;
                        r_base  <= (t_op'(i_s_tdata[4:0]) == OP_DIV) ? w_b : w_a;
                        r_exp   <= (t_op'(i_s_tdata[4:0]) == OP_POW) ? w_b : P - W'(2);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_err <= 1'b0;
                    case (r_op)
                        OP_MUL: r_state <= S_MWAIT;
                        OP_DIV, OP_INV, OP_POW: begin
                            if ((r_op == OP_DIV && r_b == '0) ||
                                (r_op == OP_INV && r_a == '0)) begin
                                r_res <= '0; r_err <= 1'b1; r_state <= S_OUT;
                            end else begin
                                r_state <= S_MWAIT;
                            end
                        end
                        OP_IDIV, OP_MOD: begin
                            if (r_b == '0) begin
                                r_res <= '0; r_err <= 1'b1; r_state <= S_OUT;
                            end else begin
                                r_state <= S_DWAIT;
                            end
                        end
                        default: begin
                            r_res <= n_simple; r_state <= S_OUT;
                        end
                    endcase
                end
                S_MWAIT: begin
                    if (w_mdone) begin
                        if (r_op == OP_MUL || r_final) begin
                            r_res <= w_prod; r_state <= S_OUT;
                        end else begin
                            r_acc   <= w_prod;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_state <= S_EXEC;
                    if (!r_phase && r_exp[r_bit]) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        if (r_bit == '0) begin
                            if (r_op == OP_DIV) begin
                                r_final <= 1'b1;
                            end else begin
                                r_res <= r_acc; r_state <= S_OUT;
                            end
                        end else begin
                            r_bit <= r_bit - 5'd1;
                        end
                    end
                end
                S_DWAIT: begin
                    if (w_ddone) begin
                        r_res <= (r_op == OP_IDIV) ? w_quo : w_rem;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {r_err, r_res};

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid)) else $error("ready while result pending");
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_res != P) else $error("result not reduced");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_err) |-> r_res == '0) else $error("error with nonzero result");
endmodule
